/* src/btpm_pkg.sv */
// Shared types and constants for the binary trie prefix match core.
// No dependencies; used by binary_trie_prefix_match_core.
package btpm_pkg;

    localparam int ADDR_BITS = 32;
    localparam logic [5:0] MAX_PLEN = 6'd32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } btpm_state_t;

endpackage

/* src/binary_trie_prefix_match_core.sv */
// Binary trie longest-prefix match core: node memory, walk sequencer, result register.
// Depends on btpm_pkg (codes, state type).
//
// One-bit-per-level IPv4 trie held in a single node memory (one read and one write
// port, registered read). Each item is transferred in and then walked one trie level
// at a time; a lookup walks until no child remains or all 32 levels are visited, and an
// insert of prefix length p walks p levels unless the node memory fills. The walk is
// paced by the node memory: one node is read or written per level. Nodes are allocated
// in order and written on allocation, so no clearing pass is needed after reset; only
// the root has a written flag. A finished result sits in the output register while the
// next item is taken; a walk that ends while the previous result is still held waits for it.
module binary_trie_prefix_match_core #(
    parameter int NODE_COUNT = 1024,
    parameter int HOP_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_length,
    input  logic [15:0] next_hop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] hop_found,
    output logic [31:0] route_count
);

    localparam int IDX = $clog2(NODE_COUNT);
    localparam int NUW = $clog2(NODE_COUNT + 1);
    localparam int EW  = 2 * IDX + 1 + HOP_BITS;

    btpm_pkg::btpm_state_t state_reg, state_next;

    logic [IDX-1:0]      node_reg, node_next;
    logic [5:0]          depth_reg, depth_next;
    logic [31:0]         shift_reg, shift_next;
    logic [5:0]          plen_reg;
    logic                op_reg;
    logic [HOP_BITS-1:0] hop_in_reg;
    logic                fresh_reg, fresh_next;
    logic                root_valid_reg;
    logic [NUW-1:0]      nodes_used_reg, nodes_used_next;
    logic [31:0]         routes_reg, routes_next;
    logic                hit_reg, hit_next;
    logic [HOP_BITS-1:0] best_reg, best_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [15:0]         hop_found_reg, hop_found_next;
    logic [31:0]         count_reg, count_next;

    logic [EW-1:0] node_mem [NODE_COUNT];
    logic [EW-1:0] mem_q_reg;
    logic          mem_we, mem_re;
    logic [IDX-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    logic                accept, go;
    logic [EW-1:0]       cur;
    logic [IDX-1:0]      cur_zero, cur_one, child, new_idx;
    logic                cur_mark, full, child_bad;
    logic [HOP_BITS-1:0] cur_hop;
    logic [HOP_BITS+15:0] hop_in_wide, best_wide;

    assign in_ready    = (state_reg == btpm_pkg::ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign go          = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hop_found   = hop_found_reg;
    assign route_count = count_reg;

    // fresh nodes and an unwritten root read as all zero
    assign cur = (fresh_reg || (node_reg == '0 && !root_valid_reg)) ? '0 : mem_q_reg;
    assign cur_zero  = cur[EW-1 -: IDX];
    assign cur_one   = cur[EW-1-IDX -: IDX];
    assign cur_mark  = cur[HOP_BITS];
    assign cur_hop   = cur[HOP_BITS-1:0];
    assign child     = shift_reg[31] ? cur_one : cur_zero;
    assign child_bad = {1'b0, child} >= (IDX+1)'(NODE_COUNT);
    assign new_idx   = nodes_used_reg[IDX-1:0];
    assign full      = nodes_used_reg >= NUW'(NODE_COUNT);

    assign hop_in_wide = {{HOP_BITS{1'b0}}, next_hop};

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        shift_next      = shift_reg;
        fresh_next      = fresh_reg;
        nodes_used_next = nodes_used_reg;
        routes_next     = routes_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        hop_found_next  = hop_found_reg;
        count_next      = count_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = node_reg;
        mem_raddr       = '0;
        mem_wdata       = cur;
        best_wide       = '0;

        case (state_reg)
            btpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // root read goes out with the transfer
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    node_next  = '0;
                    depth_next = '0;
                    shift_next = address;
                    fresh_next = 1'b0;
                    hit_next   = 1'b0;
                    best_next  = '0;
                    state_next = btpm_pkg::ST_WALK;
                end
            end
            btpm_pkg::ST_WALK:
            begin
                if (op_reg == btpm_pkg::OP_INSERT)
                begin
                    if (depth_reg == plen_reg)
                    begin
                        if (go)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata      = {cur_zero, cur_one, 1'b1, hop_in_reg};
                            routes_next    = routes_reg + 32'd1;
                            out_valid_next = 1'b1;
                            status_next    = btpm_pkg::STATUS_OK;
                            hop_found_next = '0;
                            count_next     = routes_reg + 32'd1;
                            state_next     = btpm_pkg::ST_IDLE;
                        end
                    end
                    else if (child != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = child;
                        node_next  = child;
                        depth_next = depth_reg + 6'd1;
                        shift_next = shift_reg << 1;
                        fresh_next = 1'b0;
                    end
                    else if (full)
                    begin
                        if (go)
                        begin
                            // write back so a fresh node is left with no children
                            mem_we         = 1'b1;
                            mem_wdata      = cur;
                            out_valid_next = 1'b1;
                            status_next    = btpm_pkg::STATUS_FULL;
                            hop_found_next = '0;
                            count_next     = routes_reg;
                            state_next     = btpm_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (shift_reg[31])
                            mem_wdata = {cur_zero, new_idx, cur_mark, cur_hop};
                        else
                            mem_wdata = {new_idx, cur_one, cur_mark, cur_hop};
                        node_next       = new_idx;
                        nodes_used_next = nodes_used_reg + NUW'(1);
                        depth_next      = depth_reg + 6'd1;
                        shift_next      = shift_reg << 1;
                        fresh_next      = 1'b1;
                    end
                end
                else
                begin
                    if (cur_mark)
                    begin
                        hit_next  = 1'b1;
                        best_next = cur_hop;
                    end
                    if (depth_reg == btpm_pkg::MAX_PLEN || child == '0 || child_bad)
                    begin
                        if (go)
                        begin
                            best_wide      = {16'b0, best_next};
                            out_valid_next = 1'b1;
                            status_next    = hit_next ? btpm_pkg::STATUS_OK
                                                      : btpm_pkg::STATUS_MISS;
                            hop_found_next = hit_next ? best_wide[15:0] : 16'd0;
                            count_next     = routes_reg;
                            state_next     = btpm_pkg::ST_IDLE;
                        end
                        else
                        begin
                            hit_next  = hit_reg;
                            best_next = best_reg;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = child;
                        node_next  = child;
                        depth_next = depth_reg + 6'd1;
                        shift_next = shift_reg << 1;
                    end
                end
            end
            default:
            begin
                state_next = btpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btpm_pkg::ST_IDLE;
            fresh_reg      <= 1'b0;
            root_valid_reg <= 1'b0;
            nodes_used_reg <= NUW'(1);
            routes_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fresh_reg      <= fresh_next;
            nodes_used_reg <= nodes_used_next;
            routes_reg     <= routes_next;
            out_valid_reg  <= out_valid_next;
            if (mem_we && mem_waddr == '0)
                root_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        depth_reg     <= depth_next;
        shift_reg     <= shift_next;
        hit_reg       <= hit_next;
        best_reg      <= best_next;
        status_reg    <= status_next;
        hop_found_reg <= hop_found_next;
        count_reg     <= count_next;
        if (accept)
        begin
            op_reg     <= operation;
            plen_reg   <= (prefix_length > btpm_pkg::MAX_PLEN) ? btpm_pkg::MAX_PLEN
                                                             : prefix_length;
            hop_in_reg <= hop_in_wide[HOP_BITS-1:0];
        end
    end

    // node memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= node_mem[mem_raddr];
    end

    a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg >= NUW'(1) && nodes_used_reg <= NUW'(NODE_COUNT))
        else $error("node count out of range");

    a_nodes_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (nodes_used_reg == $past(nodes_used_reg)
              || nodes_used_reg == $past(nodes_used_reg) + NUW'(1)))
        else $error("node count moved by more than one");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("node memory read and write in one cycle");

    a_fresh_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> node_reg != '0)
        else $error("root treated as a fresh node");

    a_routes_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(routes_reg) |-> out_valid_reg && status_reg == btpm_pkg::STATUS_OK)
        else $error("route count changed without an insert result");

endmodule
